[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[hw/rtl/mam_pkg.sv]
// ----------------------------------------------------------------------------
// mam_pkg
// Shared types and constants of the modular arithmetic ALU.
// ----------------------------------------------------------------------------
package mam_pkg;

  localparam int unsigned VW = 31;

  localparam logic [VW-1:0] MOD_RESET = 31'd1000000007;

  localparam logic [2:0] CMD_REDUCE = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_SUB    = 3'd2;
  localparam logic [2:0] CMD_MUL    = 3'd3;
  localparam logic [2:0] CMD_POW    = 3'd4;
  localparam logic [2:0] CMD_DIV    = 3'd5;

  // Request to the shared add/subtract-and-correct unit.
  typedef struct packed {
    logic          sub;
    logic [VW-1:0] x;
    logic [VW-1:0] y;
    logic [VW-1:0] n;
    logic          cin;
  } au_req_t;

  typedef struct packed {
    logic [VW-1:0] res;
    logic          flag;
  } au_rsp_t;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          error;
  } res_t;

endpackage

[hw/rtl/modular_arithmetic_alu_unit.sv]
// ----------------------------------------------------------------------------
// modular_arithmetic_alu_unit
// Modular ALU over a programmable modulus, built on one shared add unit.
// ----------------------------------------------------------------------------
// Usage: an item (command, operand A, operand B) is one transfer on the in_
// channel, and each item gives exactly one transfer on the out_ channel with
// the value in [0, M) and the error flag, which is set only by a divide whose
// divisor has no inverse. The modulus M is written through the cfg_ channel,
// which is always ready; write it only while no item is in flight.
// The single add-and-correct unit does one step per cycle. The operands are
// reduced first, then reduce, add and subtract finish in the execute step,
// multiply runs double-and-add over the multiplier bits, power does up to
// two multiplications per exponent bit, and divide runs Euclid steps, each
// a restoring division and a multiplication, plus a final multiplication.
// One item is worked on at a time; in_ready is high only when the sequencer
// is idle and the output register is free or emptying. Reset loads the
// modulus 1000000007 and empties the output register. If the receiver
// stalls the result waits in the output register and no new item is taken
// until that result has been transferred.
// ----------------------------------------------------------------------------
module modular_arithmetic_alu_unit import mam_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_command,
  input  logic [63:0]   in_operand_a,
  input  logic [VW-1:0] in_operand_b,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [VW-1:0] out_value,
  output logic          out_error,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [VW-1:0] cfg_modulus
);

  logic [VW-1:0] modulus_r;
  logic          out_valid_r;
  res_t          out_r;
  logic          seq_idle;
  logic          seq_done;
  res_t          seq_res;
  logic          start;

  // The configuration register can always take a write.
  assign cfg_ready = 1'b1;

  // A new item enters only when the sequencer is idle and the previous
  // result is gone or leaves in this cycle.
  assign in_ready = seq_idle && (!out_valid_r || out_ready);
  assign start    = in_valid && in_ready;

  mam_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start),
    .cmd_i   (in_command),
    .a_i     (in_operand_a),
    .b_i     (in_operand_b),
    .m_i     (modulus_r),
    .idle_o  (seq_idle),
    .done_o  (seq_done),
    .res_o   (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        modulus_r <= cfg_modulus;
      end
      if (seq_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (seq_done) begin
      out_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_r.value;
  assign out_error = out_r.error;

endmodule

[hw/rtl/mam_addmod.sv]
// ----------------------------------------------------------------------------
// mam_addmod
// Shared arithmetic unit: x + y + cin or x - y - cin, corrected once by n.
// ----------------------------------------------------------------------------
module mam_addmod import mam_pkg::*; (
  input  au_req_t req_i,
  output au_rsp_t rsp_o
);

  logic [VW:0] sum;
  logic [VW:0] dif;
  logic        ge;

  assign sum = {1'b0, req_i.x} + {1'b0, req_i.y} + {{VW{1'b0}}, req_i.cin};
  assign dif = {1'b0, req_i.x} - {1'b0, req_i.y} - {{VW{1'b0}}, req_i.cin};
  assign ge  = (sum >= {1'b0, req_i.n});

  // In add mode the flag reports a subtraction of n (a quotient bit when
  // dividing); in subtract mode it reports the borrow.
  always_comb begin
    if (req_i.sub) begin
      rsp_o.flag = dif[VW];
      rsp_o.res  = dif[VW] ? (dif[VW-1:0] + req_i.n) : dif[VW-1:0];
    end else begin
      rsp_o.flag = ge;
      rsp_o.res  = ge ? (sum[VW-1:0] - req_i.n) : sum[VW-1:0];
    end
  end

endmodule

[hw/rtl/mam_seq.sv]
// ----------------------------------------------------------------------------
// mam_seq
// Sequencer that runs every command as steps of the shared add/sub unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mam_seq import mam_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_i,
  input  logic [2:0]    cmd_i,
  input  logic [63:0]   a_i,
  input  logic [VW-1:0] b_i,
  input  logic [VW-1:0] m_i,
  output logic          idle_o,
  output logic          done_o,
  output res_t          res_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RAFIX, S_RB, S_EXEC, S_MUL, S_FIN, S_POW, S_POWA, S_POWB,
    S_EU, S_DIVQ, S_EUT, S_DONE
  } state_t;

  state_t        state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [VW-1:0] m_r, m_nxt;
  logic [63:0]   src_r, src_nxt;
  logic          neg_r, neg_nxt;
  logic [VW-1:0] braw_r, braw_nxt;
  logic [VW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          ph_r, ph_nxt;
  logic [VW-1:0] mx_r, mx_nxt, my_r, my_nxt, mr_r, mr_nxt;
  logic [VW-1:0] acc_r, acc_nxt, base_r, base_nxt, e_r, e_nxt;
  logic [VW-1:0] r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic [VW-1:0] rem_r, rem_nxt, q_r, q_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic          err_r, err_nxt;
  au_req_t       req;
  au_rsp_t       rsp;

  mam_addmod u_addmod (
    .req_i (req),
    .rsp_o (rsp)
  );

  assign idle_o      = (state_r == S_IDLE);
  assign done_o      = (state_r == S_DONE);
  assign res_o.value = val_r;
  assign res_o.error = err_r;

  always_comb begin
    state_nxt = state_r;  ret_nxt  = ret_r;   cmd_nxt  = cmd_r;   m_nxt   = m_r;
    src_nxt   = src_r;    neg_nxt  = neg_r;   braw_nxt = braw_r;  a_nxt   = a_r;
    b_nxt     = b_r;      cnt_nxt  = cnt_r;   ph_nxt   = ph_r;    mx_nxt  = mx_r;
    my_nxt    = my_r;     mr_nxt   = mr_r;    acc_nxt  = acc_r;   base_nxt = base_r;
    e_nxt     = e_r;      r0_nxt   = r0_r;    r1_nxt   = r1_r;    t0_nxt  = t0_r;
    t1_nxt    = t1_r;     rem_nxt  = rem_r;   q_nxt    = q_r;     val_nxt = val_r;
    err_nxt   = err_r;
    req.sub = 1'b0;
    req.x   = mr_r;
    req.y   = mr_r;
    req.n   = m_r;
    req.cin = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start_i) begin
          cmd_nxt  = cmd_i;
          m_nxt    = m_i;
          neg_nxt  = a_i[63];
          src_nxt  = a_i[63] ? ~a_i : a_i;
          braw_nxt = b_i;
          mr_nxt   = '0;
          cnt_nxt  = 6'd63;
          val_nxt  = '0;
          err_nxt  = 1'b0;
          state_nxt = (m_i < 31'd2) ? S_DONE : S_RA;
        end
      end
      S_RA: begin
        req.cin = src_r[cnt_r];
        mr_nxt  = rsp.res;
        if (cnt_r == 6'd0) begin
          state_nxt = S_RAFIX;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      S_RAFIX: begin
        // A negative operand was reduced as its complement: m - 1 - r.
        req.sub   = 1'b1;
        req.x     = '0;
        req.cin   = 1'b1;
        a_nxt     = neg_r ? rsp.res : mr_r;
        mr_nxt    = '0;
        cnt_nxt   = 6'd30;
        state_nxt = S_RB;
      end
      S_RB: begin
        req.cin = braw_r[cnt_r[4:0]];
        mr_nxt  = rsp.res;
        if (cnt_r == 6'd0) begin
          b_nxt     = rsp.res;
          state_nxt = S_EXEC;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      S_EXEC: begin
        req.x = a_r;
        req.y = b_r;
        case (cmd_r)
          CMD_REDUCE: begin
            val_nxt   = a_r;
            state_nxt = S_DONE;
          end
          CMD_ADD: begin
            val_nxt   = rsp.res;
            state_nxt = S_DONE;
          end
          CMD_SUB: begin
            req.sub   = 1'b1;
            val_nxt   = rsp.res;
            state_nxt = S_DONE;
          end
          CMD_MUL: begin
            mx_nxt = a_r;  my_nxt = b_r;  mr_nxt = '0;
            cnt_nxt = 6'd30;  ph_nxt = 1'b0;  ret_nxt = S_FIN;
            state_nxt = S_MUL;
          end
          CMD_POW: begin
            acc_nxt   = {{(VW-1){1'b0}}, 1'b1};
            base_nxt  = a_r;
            e_nxt     = braw_r;
            state_nxt = S_POW;
          end
          CMD_DIV: begin
            if (b_r == '0) begin
              err_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              r0_nxt = m_r;  r1_nxt = b_r;
              t0_nxt = '0;   t1_nxt = {{(VW-1){1'b0}}, 1'b1};
              state_nxt = S_EU;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_MUL: begin
        // Double-and-add over the multiplier bits, most significant first.
        if (!ph_r) begin
          mr_nxt = rsp.res;
          if (my_r[cnt_r[4:0]]) begin
            ph_nxt = 1'b1;
          end else if (cnt_r == 6'd0) begin
            state_nxt = ret_r;
          end else begin
            cnt_nxt = cnt_r - 6'd1;
          end
        end else begin
          req.y  = mx_r;
          mr_nxt = rsp.res;
          ph_nxt = 1'b0;
          if (cnt_r == 6'd0) begin
            state_nxt = ret_r;
          end else begin
            cnt_nxt = cnt_r - 6'd1;
          end
        end
      end
      S_FIN: begin
        val_nxt   = mr_r;
        state_nxt = S_DONE;
      end
      S_POW: begin
        if (e_r == '0) begin
          val_nxt   = acc_r;
          state_nxt = S_DONE;
        end else if (e_r[0]) begin
          mx_nxt = acc_r;  my_nxt = base_r;  mr_nxt = '0;
          cnt_nxt = 6'd30;  ph_nxt = 1'b0;  ret_nxt = S_POWA;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_POWA;
        end
      end
      S_POWA: begin
        if (e_r[0]) begin
          acc_nxt = mr_r;
        end
        mx_nxt = base_r;  my_nxt = base_r;  mr_nxt = '0;
        cnt_nxt = 6'd30;  ph_nxt = 1'b0;  ret_nxt = S_POWB;
        state_nxt = S_MUL;
      end
      S_POWB: begin
        base_nxt  = mr_r;
        e_nxt     = e_r >> 1;
        state_nxt = S_POW;
      end
      S_EU: begin
        if (r1_r == '0) begin
          if (r0_r != {{(VW-1){1'b0}}, 1'b1}) begin
            err_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            mx_nxt = a_r;  my_nxt = t0_r;  mr_nxt = '0;
            cnt_nxt = 6'd30;  ph_nxt = 1'b0;  ret_nxt = S_FIN;
            state_nxt = S_MUL;
          end
        end else begin
          rem_nxt   = '0;
          q_nxt     = '0;
          cnt_nxt   = 6'd30;
          state_nxt = S_DIVQ;
        end
      end
      S_DIVQ: begin
        // Restoring division of r0 by r1, one quotient bit per cycle.
        req.x   = rem_r;
        req.y   = rem_r;
        req.n   = r1_r;
        req.cin = r0_r[cnt_r[4:0]];
        rem_nxt = rsp.res;
        q_nxt   = {q_r[VW-2:0], rsp.flag};
        if (cnt_r == 6'd0) begin
          mx_nxt = t1_r;  my_nxt = {q_r[VW-2:0], rsp.flag};  mr_nxt = '0;
          cnt_nxt = 6'd30;  ph_nxt = 1'b0;  ret_nxt = S_EUT;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      S_EUT: begin
        req.sub   = 1'b1;
        req.x     = t0_r;
        req.y     = mr_r;
        r0_nxt    = r1_r;
        r1_nxt    = rem_r;
        t0_nxt    = t1_r;
        t1_nxt    = rsp.res;
        state_nxt = S_EU;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
    cmd_r <= cmd_nxt;   m_r   <= m_nxt;    src_r  <= src_nxt;  neg_r  <= neg_nxt;
    braw_r <= braw_nxt; a_r   <= a_nxt;    b_r    <= b_nxt;    cnt_r  <= cnt_nxt;
    ph_r  <= ph_nxt;    mx_r  <= mx_nxt;   my_r   <= my_nxt;   mr_r   <= mr_nxt;
    acc_r <= acc_nxt;   base_r <= base_nxt; e_r   <= e_nxt;    r0_r   <= r0_nxt;
    r1_r  <= r1_nxt;    t0_r  <= t0_nxt;   t1_r   <= t1_nxt;   rem_r  <= rem_nxt;
    q_r   <= q_nxt;     val_r <= val_nxt;  err_r  <= err_nxt;
  end

  `ASSERT_NEVER(a_start_busy, start_i && (state_r != S_IDLE))
  `ASSERT_PROP(a_val_range, done_o && (m_r >= 31'd2) |-> (val_r < m_r))
  `ASSERT_PROP(a_err_div, done_o && err_r |-> (cmd_r == CMD_DIV) && (val_r == '0))

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Modular arithmetic ALU testbench
// Drives command and operand transfers under random sender bursts and
// receiver stalls, rewrites the modulus between phases, and compares every
// result transfer against a predictor that evaluates each command directly.
// ----------------------------------------------------------------------------
module testbench import mam_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Command codes that the block leaves unused; they must give value 0.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // No transfer of any kind for this many cycles ends the run. The limit
  // covers the slowest item (power or a long Euclid run) together with the
  // long receiver hold.
  localparam int unsigned IDLE_LIMIT = 60000;
  localparam int unsigned LONG_HOLD  = 400;

  // --------------------------------------------------------------------------
  // Expected-result store and modular predictor.
  // --------------------------------------------------------------------------
  class mod_alu_scoreboard;
    longint unsigned modulus;
    res_t            pending_q[$];
    int unsigned     mismatches;
    int unsigned     results_seen;
    int unsigned     div_errors_seen;

    function new();
      modulus = 64'(MOD_RESET);
    endfunction

    // Maps a signed 64-bit operand into [0, m).
    function longint unsigned fold_signed(logic [63:0] raw, longint unsigned m);
      if (!raw[63]) return raw % m;
      return (m - 1) - ((~raw) % m);
    endfunction

    function longint unsigned mod_pow(longint unsigned base, longint unsigned e,
                                      longint unsigned m);
      longint unsigned acc;
      acc = 1 % m;
      while (e != 0) begin
        if (e[0]) acc = (acc * base) % m;
        base = (base * base) % m;
        e = e >> 1;
      end
      return acc;
    endfunction

    // Extended Euclid; returns 0 when d has no inverse, else 1 with the inverse in inv.
    function bit mod_inverse(longint unsigned d, longint unsigned m,
                             output longint unsigned inv);
      longint r0, r1, t0, t1, q, tmp;
      r0 = m;
      r1 = d;
      t0 = 0;
      t1 = 1;
      inv = 0;
      while (r1 != 0) begin
        q = r0 / r1;
        tmp = r0 - q * r1;
        r0 = r1;
        r1 = tmp;
        tmp = t0 - q * t1;
        t0 = t1;
        t1 = tmp;
      end
      if (r0 != 1) return 0;
      if (t0 < 0) t0 = t0 + longint'(m);
      inv = longint'(t0) % m;
      return 1;
    endfunction

    // Called for every accepted input transfer.
    function void note_item(logic [2:0] cmd, logic [63:0] op_a, logic [VW-1:0] op_b);
      res_t            r;
      longint unsigned m, a, b, inv;
      m = modulus;
      r.value = '0;
      r.error = 1'b0;
      if (m >= 2) begin
        a = fold_signed(op_a, m);
        b = longint'(op_b) % m;
        case (cmd)
          CMD_REDUCE: r.value = VW'(a);
          CMD_ADD:    r.value = VW'((a + b) % m);
          CMD_SUB:    r.value = VW'((a + m - b) % m);
          CMD_MUL:    r.value = VW'((a * b) % m);
          CMD_POW:    r.value = VW'(mod_pow(a, longint'(op_b), m));
          CMD_DIV: begin
            if (b != 0 && mod_inverse(b, m, inv)) r.value = VW'((a * inv) % m);
            else r.error = 1'b1;
          end
          default: ;
        endcase
      end
      pending_q = {pending_q, r};
    endfunction

    // Called for every accepted result transfer.
    function void check_result(logic [VW-1:0] value, logic error);
      res_t exp_r;
      results_seen++;
      if (error) div_errors_seen++;
      if (pending_q.size() == 0) begin
        $error("result with no item outstanding: value %0d error %0d", value, error);
        mismatches++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (value !== exp_r.value) begin
        $error("value: expected %0d, got %0d", exp_r.value, value);
        mismatches++;
      end
      if (error !== exp_r.error) begin
        $error("error: expected %0d, got %0d", exp_r.error, error);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid, in_ready;
  logic [2:0]    in_command;
  logic [63:0]   in_operand_a;
  logic [VW-1:0] in_operand_b;
  logic          out_valid, out_ready;
  logic [VW-1:0] out_value;
  logic          out_error;
  logic          cfg_valid, cfg_ready;
  logic [VW-1:0] cfg_modulus;

  mod_alu_scoreboard sb = new();

  // Sender burst state and run statistics.
  bit          gaps_on;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned cmd_count[8];
  int unsigned moduli_written;

  always #4 clk = ~clk;

  modular_arithmetic_alu_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_error    (out_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_modulus  (cfg_modulus)
  );

  // --------------------------------------------------------------------------
  // Result monitor. Sampling at the rising edge sees the values from before
  // the edge, so the transfer condition matches what the block sees.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_value, out_error);
  end

  // --------------------------------------------------------------------------
  // Receiver. It alternates between stretches of steady readiness and
  // stretches of random stalls. Once, after forty results, it holds off for a
  // long stretch so that the output register fills and in_ready drops while
  // the sender keeps offering.
  // --------------------------------------------------------------------------
  int unsigned hold_left;
  int unsigned mode_left;
  bit          stall_mode;
  bit          long_hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      mode_left <= 0;
      stall_mode <= 1'b0;
      long_hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && sb.results_seen >= 40) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= 1'($urandom_range(0, 1));
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      out_ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles without any transfer.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL modular_arithmetic_alu_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks.
  // --------------------------------------------------------------------------

  // One item transfer. When gaps are enabled the sender works in bursts and
  // drops valid for a random gap between them.
  task automatic send_item(logic [2:0] cmd, logic [63:0] op_a, logic [VW-1:0] op_b);
    int unsigned gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_operand_a <= op_a;
    in_operand_b <= op_b;
    do @(posedge clk); while (!in_ready);
    sb.note_item(cmd, op_a, op_b);
    items_sent++;
    cmd_count[cmd]++;
  endtask

  // Drops valid and waits until every expected result has been transferred.
  // Every item yields a result, so the block is idle afterwards.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Writes the modulus; only called while the block is idle.
  task automatic write_modulus(logic [VW-1:0] m);
    cfg_valid   <= 1'b1;
    cfg_modulus <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.modulus = 64'(m);
    moduli_written++;
  endtask

  // Random item. Exponents are mostly short so that power stays cheap, with
  // a share of full-width ones; operand A mixes full 64-bit patterns with
  // small values of either sign.
  task automatic send_random_item();
    logic [2:0]    cmd;
    logic [63:0]   op_a;
    logic [VW-1:0] op_b;
    cmd = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0:       op_a = 64'($urandom_range(0, 100));
      1:       op_a = -64'($urandom_range(1, 100));
      default: op_a = {$urandom, $urandom};
    endcase
    op_b = VW'($urandom);
    if (cmd == CMD_POW && $urandom_range(0, 3) != 0) op_b = VW'($urandom_range(0, 300));
    else if ($urandom_range(0, 5) == 0) op_b = VW'($urandom_range(0, 3));
    send_item(cmd, op_a, op_b);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  logic [VW-1:0] phase_mod[8];
  logic [VW-1:0] max_b;
  logic [63:0]   a_min, a_max;

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= CMD_REDUCE;
    in_operand_a <= '0;
    in_operand_b <= '0;
    cfg_valid    <= 1'b0;
    cfg_modulus  <= MOD_RESET;
    gaps_on      = 1'b0;
    burst_left   = 0;
    max_b        = '1;
    a_min        = 64'h8000_0000_0000_0000;
    a_max        = 64'h7FFF_FFFF_FFFF_FFFF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items on the reset modulus, sent back to back.
    send_item(CMD_REDUCE, a_min, 0);
    send_item(CMD_REDUCE, a_max, 0);
    send_item(CMD_REDUCE, '1, 0);
    send_item(CMD_REDUCE, 64'd1000000007, 0);
    send_item(CMD_ADD, a_max, max_b);
    send_item(CMD_ADD, -64'd1, 1);
    send_item(CMD_SUB, 0, max_b);
    send_item(CMD_SUB, a_min, 5);
    send_item(CMD_MUL, a_min, max_b);
    send_item(CMD_MUL, '1, max_b);
    // A zero exponent gives one, also for a zero base.
    send_item(CMD_POW, 0, 0);
    send_item(CMD_POW, a_min, 0);
    send_item(CMD_POW, 2, max_b);
    send_item(CMD_POW, '1, max_b - 1'b1);
    send_item(CMD_DIV, 10, 3);
    send_item(CMD_DIV, a_max, max_b);
    // Zero divisor, directly and after reduction.
    send_item(CMD_DIV, 7, 0);
    send_item(CMD_DIV, 7, VW'(MOD_RESET));
    send_item(CMD_SPARE_6, a_max, max_b);
    send_item(CMD_SPARE_7, '1, 3);

    // The sender pauses here until the block has returned every result.
    drain_results();

    // Random phases, each on its own modulus: both extremes, the degenerate
    // values zero and one, a composite one so that division finds shared
    // factors, a small prime, a random value and the reset modulus.
    phase_mod[0] = 31'h7FFF_FFFF;
    phase_mod[1] = 31'd2;
    phase_mod[2] = 31'd1000000;
    phase_mod[3] = 31'd0;
    phase_mod[4] = 31'd97;
    phase_mod[5] = 31'd1;
    phase_mod[6] = VW'($urandom_range(3, 32'h7FFF_FFFF));
    phase_mod[7] = MOD_RESET;
    gaps_on = 1'b1;
    foreach (phase_mod[p]) begin
      write_modulus(phase_mod[p]);
      // One phase runs without sender gaps.
      gaps_on = (p != 4);
      repeat (34) send_random_item();
      drain_results();
    end

    // The block holds at most one item in flight, so a short wait suffices.
    repeat (200) @(posedge clk);

    $display("Sent %0d items over %0d modulus settings; %0d divide errors flagged.",
             items_sent, moduli_written + 1, sb.div_errors_seen);
    $display("Commands reduce/add/sub/mul/pow/div/spare: %0d %0d %0d %0d %0d %0d %0d",
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4],
             cmd_count[5], cmd_count[6] + cmd_count[7]);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASS modular_arithmetic_alu_unit");
    end else begin
      if (sb.pending_q.size() != 0)
        $error("%0d expected results never arrived", sb.pending_q.size());
      $display("FAIL modular_arithmetic_alu_unit");
    end
    $finish;
  end

endmodule
